/* hw/rtl/ucs_pkg.sv */
package ucs_pkg;

   localparam int unsigned TAIL_MAX = 4;
   localparam int unsigned HELD_MAX = 3;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      byte_type in_byte;
      logic     in_end;
   } req_type;

   typedef struct packed {
      byte_type out_byte;
      logic     run_last;
      logic     text_end;
   } rsp_type;

   // One command per item: rep_count replacement characters, then tail_len literal bytes.
   typedef struct packed {
      logic [2:0]                  rep_count;
      logic [2:0]                  tail_len;
      byte_type [TAIL_MAX-1:0]     tail;
      logic                        text_end;
   } cmd_type;

   localparam byte_type CONT_MASK  = 8'hC0;
   localparam byte_type CONT_CODE  = 8'h80;
   localparam byte_type LEAD2_MASK = 8'hE0;
   localparam byte_type LEAD2_CODE = 8'hC0;
   localparam byte_type LEAD3_MASK = 8'hF0;
   localparam byte_type LEAD3_CODE = 8'hE0;
   localparam byte_type LEAD4_MASK = 8'hF8;
   localparam byte_type LEAD4_CODE = 8'hF0;
   localparam byte_type CHAR_DEL   = 8'h7F;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_TAB   = 8'h09;
   localparam byte_type CHAR_LF    = 8'h0A;
   localparam byte_type CHAR_CR    = 8'h0D;
   localparam byte_type ESC_OPEN   = 8'h3C;
   localparam byte_type ESC_CLOSE  = 8'h3E;
   localparam byte_type REPL_BYTE0 = 8'hEF;
   localparam byte_type REPL_BYTE1 = 8'hBF;
   localparam byte_type REPL_BYTE2 = 8'hBD;

   localparam logic [1:0] REPL_PHASE_FIRST = 2'd0;
   localparam logic [1:0] REPL_PHASE_MID   = 2'd1;
   localparam logic [1:0] REPL_PHASE_LAST  = 2'd2;

   function automatic byte_type hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'd0, nib};
      end else begin
         return 8'h37 + {4'd0, nib};
      end
   endfunction

   function automatic byte_type repl_byte(input logic [1:0] phase);
      byte_type b;
      unique case (phase)
         REPL_PHASE_FIRST: b = REPL_BYTE0;
         REPL_PHASE_MID:   b = REPL_BYTE1;
         default:          b = REPL_BYTE2;
      endcase
      return b;
   endfunction

endpackage

/* hw/rtl/ucs_front.sv */
module ucs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  ucs_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output ucs_pkg::cmd_type q_cmd
);
   import ucs_pkg::*;

   byte_type   pend_ff [HELD_MAX];
   logic [1:0] count_ff, count_in;
   logic [2:0] exp_ff, exp_in;
   logic       pend_wr;
   logic [1:0] pend_idx;
   logic       accept;
   logic       is_cont, is_ctrl;
   logic [2:0] lead_len;
   logic [2:0] pre_rep;
   byte_type   b;
   cmd_type    cmd;

   always_comb begin
      b        = req_data.in_byte;
      accept   = req_push && !q_full;
      is_cont  = (b & CONT_MASK) == CONT_CODE;
      is_ctrl  = ((b < CHAR_SPACE) && (b != CHAR_TAB) && (b != CHAR_LF) && (b != CHAR_CR))
                 || (b == CHAR_DEL);
      priority if ((b & LEAD2_MASK) == LEAD2_CODE) lead_len = 3'd2;
      else if ((b & LEAD3_MASK) == LEAD3_CODE)     lead_len = 3'd3;
      else if ((b & LEAD4_MASK) == LEAD4_CODE)     lead_len = 3'd4;
      else                                         lead_len = 3'd0;

      count_in = count_ff;
      exp_in   = exp_ff;
      pend_wr  = 1'b0;
      pend_idx = count_ff;
      pre_rep  = '0;
      cmd      = '0;
      cmd.text_end = req_data.in_end;

      if ((exp_ff != 3'd0) && is_cont) begin
         if (({1'b0, count_ff} + 3'd1) >= exp_ff) begin
            // complete sequence: release held bytes with this one
            cmd.tail[0]  = pend_ff[0];
            cmd.tail[1]  = (count_ff == 2'd1) ? b : pend_ff[1];
            cmd.tail[2]  = (count_ff == 2'd2) ? b : pend_ff[2];
            cmd.tail[3]  = b;
            cmd.tail_len = {1'b0, count_ff} + 3'd1;
            count_in     = '0;
            exp_in       = '0;
         end else begin
            pend_wr  = 1'b1;
            count_in = count_ff + 2'd1;
            if (req_data.in_end) begin
               cmd.rep_count = {1'b0, count_ff} + 3'd1;
               count_in      = '0;
               exp_in        = '0;
            end
         end
      end else begin
         // drop whatever was held, then treat the byte afresh
         pre_rep  = (exp_ff != 3'd0) ? {1'b0, count_ff} : 3'd0;
         count_in = '0;
         exp_in   = '0;
         cmd.rep_count = pre_rep;
         if (is_ctrl) begin
            cmd.tail[0]  = ESC_OPEN;
            cmd.tail[1]  = hex_char(b[7:4]);
            cmd.tail[2]  = hex_char(b[3:0]);
            cmd.tail[3]  = ESC_CLOSE;
            cmd.tail_len = 3'd4;
         end else if (!b[7]) begin
            cmd.tail[0]  = b;
            cmd.tail_len = 3'd1;
         end else if (lead_len != 3'd0) begin
            pend_wr  = 1'b1;
            pend_idx = 2'd0;
            if (req_data.in_end) begin
               cmd.rep_count = pre_rep + 3'd1;
            end else begin
               count_in = 2'd1;
               exp_in   = lead_len;
            end
         end else begin
            cmd.rep_count = pre_rep + 3'd1;
         end
      end

      q_cmd  = cmd;
      q_push = accept && ((cmd.rep_count != 3'd0) || (cmd.tail_len != 3'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         exp_ff   <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         exp_ff   <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pend_wr) begin
         pend_ff[pend_idx] <= b;
      end
   end

endmodule

/* hw/rtl/ucs_queue.sv */
module ucs_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ucs_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output ucs_pkg::cmd_type head_cmd,
   output logic             empty
);
   import ucs_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   always_comb begin
      full     = cnt_ff == CNT_FULL;
      empty    = cnt_ff == '0;
      head_cmd = slot_ff[rd_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_in    = do_push ? ((wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? ((rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in   = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/ucs_back.sv */
module ucs_back (
   input  logic             clock,
   input  logic             reset,
   input  ucs_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output ucs_pkg::rsp_type rsp_data
);
   import ucs_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [2:0] rep_done_ff, rep_done_in;
   logic [1:0] tail_idx_ff, tail_idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       take, in_rep, last;

   always_comb begin
      take   = cmd_valid && (!valid_ff || rsp_pop);
      in_rep = rep_done_ff < cmd.rep_count;
      if (in_rep) begin
         last = (phase_ff == REPL_PHASE_LAST) && ((rep_done_ff + 3'd1) == cmd.rep_count)
                && (cmd.tail_len == 3'd0);
         rsp_in.out_byte = repl_byte(phase_ff);
      end else begin
         last = ({1'b0, tail_idx_ff} + 3'd1) == cmd.tail_len;
         rsp_in.out_byte = cmd.tail[tail_idx_ff];
      end
      rsp_in.run_last = last;
      rsp_in.text_end = last && cmd.text_end;

      phase_in    = phase_ff;
      rep_done_in = rep_done_ff;
      tail_idx_in = tail_idx_ff;
      if (take) begin
         if (last) begin
            phase_in    = REPL_PHASE_FIRST;
            rep_done_in = '0;
            tail_idx_in = '0;
         end else if (in_rep) begin
            if (phase_ff == REPL_PHASE_LAST) begin
               phase_in    = REPL_PHASE_FIRST;
               rep_done_in = rep_done_ff + 3'd1;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end else begin
            tail_idx_in = tail_idx_ff + 2'd1;
         end
      end

      cmd_pop   = take && last;
      valid_in  = take || (valid_ff && !rsp_pop);
      rsp_empty = !valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= REPL_PHASE_FIRST;
         rep_done_ff <= '0;
         tail_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         rep_done_ff <= rep_done_in;
         tail_idx_ff <= tail_idx_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* hw/rtl/utf8_control_char_sanitizer_unit.sv */
// UTF-8 control character sanitiser.
// Request side is a queue write port: a byte of text with its end-of-text flag is
// transferred on a rising edge with req_push high and req_full low. Response side is a
// queue read port: while rsp_empty is low the oldest output byte sits on rsp_data and
// is transferred on an edge with rsp_pop high.
// Each input byte yields zero to thirteen output bytes; run_last marks the last byte
// caused by one input and text_end the final byte of the text.
// An item's first output byte passes the command queue, then the output register.
// Throughput: one input byte per cycle while each yields one output byte and rsp_pop stays
// high. The output expander emits one byte per cycle while rsp_pop keeps up, so an item
// producing more bytes holds it until all are out; the command queue (QUEUE_DEPTH entries)
// absorbs this and req_full rises once it fills.
// A held lead byte produces nothing until its sequence completes or breaks.
// A stalled receiver keeps rsp_data steady; the expander then stops, the queue fills
// and req_full holds the sender off. No transfer is lost.
// Reset (synchronous, active high) empties queue and output register and discards any
// held partial sequence.
module utf8_control_char_sanitizer_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  ucs_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ucs_pkg::rsp_type rsp_data
);
   import ucs_pkg::*;

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_push_cmd, q_head_cmd;

   // front: classify each byte, track the held sequence and issue at most one command
   ucs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_push_cmd)
   );

   // short queue so classification and expansion stall independently
   ucs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (q_head_cmd),
      .empty    (q_empty)
   );

   // back: expand each command into bytes, one per cycle while the output register is free
   ucs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_head_cmd),
      .cmd_valid (!q_empty),
      .cmd_pop   (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // hold the sender off whenever the command queue has no room
   assign req_full = q_full;

endmodule

/* test/tb_top.sv */
module tb_top;
   import ucs_pkg::*;

   // Cycles without a single transfer on either side before the run is called hung.
   // The longest quiet stretch is the deliberate receiver hold-off in the pressure test.
   localparam int unsigned IDLE_LIMIT   = 2000;
   // Settle time after the last byte has come out: output latency plus margin.
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned RSP_HOLD_LEN = 120;
   localparam int unsigned RANDOM_ITEMS = 275;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   // Sanitised bytes still to come out of the block, oldest first.
   rsp_type clean_text_q[$];
   int      mismatch_count = 0;
   int      step_n;

   // Shadow copy of the partial UTF-8 sequence the block is holding.
   byte_type seq_held [3];
   int       seq_held_n = 0;
   int       seq_len    = 0;

   // Idling knobs shared between the test tasks, the sending task and the receiver process.
   bit sender_gaps     = 1'b1;
   bit receiver_gaps   = 1'b1;
   int rsp_hold_cycles = 0;

   string hex_set = "0123456789ABCDEF";

   utf8_control_char_sanitizer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Sanitiser prediction
   // ------------------------------------------------------------------

   // Append one output byte of the current input byte; the run flags are fixed up later.
   function automatic void put_out(input byte_type b);
      rsp_type r;
      r.out_byte = b;
      r.run_last = 1'b0;
      r.text_end = 1'b0;
      clean_text_q.push_back(r);
      step_n++;
   endfunction

   // U+FFFD in UTF-8.
   function automatic void put_repl();
      put_out(REPL_BYTE0);
      put_out(REPL_BYTE1);
      put_out(REPL_BYTE2);
   endfunction

   // Drop the held sequence: one replacement character per held byte.
   function automatic void drop_seq();
      for (int i = 0; i < seq_held_n; i++) begin
         put_repl();
      end
      seq_held_n = 0;
      seq_len    = 0;
   endfunction

   // Handle a byte with nothing held: escape, pass through, start a sequence or replace.
   function automatic void take_fresh(input byte_type b);
      int len;
      len = 0;
      if ((b < CHAR_SPACE && b != CHAR_TAB && b != CHAR_LF && b != CHAR_CR) ||
          b == CHAR_DEL) begin
         put_out(ESC_OPEN);
         put_out(hex_set[b[7:4]]);
         put_out(hex_set[b[3:0]]);
         put_out(ESC_CLOSE);
      end else if (!b[7]) begin
         put_out(b);
      end else begin
         if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            len = 2;
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            len = 3;
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            len = 4;
         end
         if (len == 0) begin
            // stray continuation byte or 0xF8..0xFF
            put_repl();
         end else begin
            seq_held[0] = b;
            seq_held_n  = 1;
            seq_len     = len;
         end
      end
   endfunction

   // Work out every output byte caused by one accepted input byte.
   function automatic void sanitize_byte(input byte_type b, input logic fin);
      step_n = 0;
      if (seq_len != 0) begin
         if ((b & CONT_MASK) == CONT_CODE) begin
            if (seq_held_n + 1 >= seq_len) begin
               // sequence complete: release it unchanged
               for (int i = 0; i < seq_held_n; i++) begin
                  put_out(seq_held[i]);
               end
               put_out(b);
               seq_held_n = 0;
               seq_len    = 0;
            end else begin
               seq_held[seq_held_n] = b;
               seq_held_n++;
            end
         end else begin
            // broken sequence: replace what is held, then treat the byte afresh
            drop_seq();
            take_fresh(b);
         end
      end else begin
         take_fresh(b);
      end
      // a sequence cut off by the end of the text is replaced byte for byte
      if (fin && seq_len != 0) begin
         drop_seq();
      end
      if (step_n > 0) begin
         clean_text_q[clean_text_q.size() - 1].run_last = 1'b1;
         clean_text_q[clean_text_q.size() - 1].text_end = fin;
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one byte after a random gap and hold it until the block takes it. Values are
   // driven at the rising edge and sampled at the falling edge, where they are steady up
   // to the edge that completes the transfer. Return on that edge with req_push still
   // high, so a back-to-back byte never lowers and raises it in the same step.
   task automatic send_byte(input byte_type b, input logic fin);
      req_type r;
      int      gap;
      r.in_byte = b;
      r.in_end  = fin;
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (req_full);
      // the transfer completes at the coming edge: record what it must produce
      sanitize_byte(b, fin);
      @(posedge clock);
   endtask

   // Send a whole text, flagging its final byte.
   task automatic send_text(input byte_type text[$]);
      foreach (text[i]) begin
         send_byte(text[i], i == text.size() - 1);
      end
   endtask

   function automatic byte_type utf8_cont();
      return CONT_CODE | byte_type'($urandom_range(0, 63));
   endfunction

   function automatic byte_type utf8_lead(input int len);
      case (len)
         2:       return LEAD2_CODE | byte_type'($urandom_range(0, 31));
         3:       return LEAD3_CODE | byte_type'($urandom_range(0, 15));
         default: return LEAD4_CODE | byte_type'($urandom_range(0, 7));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_output(input rsp_type got);
      rsp_type want;
      if (clean_text_q.size() == 0) begin
         report_mismatch("out_byte with nothing pending", got.out_byte, 0);
      end else begin
         want = clean_text_q.pop_front();
         if (got.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", got.out_byte, want.out_byte);
         end
         if (got.run_last !== want.run_last) begin
            report_mismatch("run_last", got.run_last, want.run_last);
         end
         if (got.text_end !== want.text_end) begin
            report_mismatch("text_end", got.text_end, want.text_end);
         end
      end
   endtask

   // Receiver: per byte, idle for a random number of cycles (or a long hold-off when a
   // test asks for one), then pop and compare the byte at the falling edge before the
   // transfer.
   initial begin : rsp_drain
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = receiver_gaps ? $urandom_range(0, 5) : 0;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(negedge clock); while (rsp_empty);
         check_output(rsp_data);
         @(posedge clock);
      end
   end

   // Watchdog: count cycles with no transfer on either side; give up at the limit.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(negedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Control bytes at both ends of the range, DEL, and the three whitespace bytes that
   // pass through; finish on the top printable byte.
   task automatic test_ascii_and_controls();
      byte_type text[$];
      text = '{8'h00, 8'h1F, CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_DEL, 8'h7E};
      send_text(text);
   endtask

   // Complete two, three and four byte sequences, the last one at the top code point.
   task automatic test_valid_sequences();
      byte_type text[$];
      text = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text(text);
   endtask

   // Stray continuation, invalid lead, broken two byte sequence, a three byte hold broken
   // by a control byte (the longest expansion), and a sequence cut off by the text end.
   task automatic test_invalid_sequences();
      byte_type text[$];
      text = '{8'h80, 8'hF8, 8'hC3, 8'h41, 8'hF0, 8'h9F, 8'h98, 8'h01, 8'hE2, 8'h82};
      send_text(text);
   endtask

   // Hold the receiver off for a long stretch while bytes are offered back to back, so
   // the block fills up and raises req_full.
   task automatic test_backpressure();
      byte_type text[$];
      for (int i = 0; i < 30; i++) begin
         text.push_back(($urandom_range(0, 2) == 0) ? byte_type'($urandom_range(0, 31))
                                                    : byte_type'($urandom_range(32, 126)));
      end
      sender_gaps     = 1'b0;
      rsp_hold_cycles = RSP_HOLD_LEN;
      send_text(text);
      sender_gaps = 1'b1;
   endtask

   // Random texts built mostly from well-formed pieces with random content, mixed with
   // control bytes, noise and truncated sequences. Idling is re-drawn per text so some
   // texts run with no gaps at all on one side or both.
   task automatic test_random_texts();
      byte_type text[$];
      int       sent;
      int       len;
      int       k;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         text.delete();
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
               0, 1, 2: text.push_back(byte_type'($urandom_range(32, 126)));
               3: begin
                  k = $urandom_range(0, 32);
                  text.push_back((k == 32) ? CHAR_DEL : byte_type'(k));
               end
               4, 5, 6: begin
                  len = $urandom_range(2, 4);
                  text.push_back(utf8_lead(len));
                  repeat (len - 1) text.push_back(utf8_cont());
               end
               7: text.push_back(byte_type'($urandom_range(0, 255)));
               default: begin
                  // truncated: the next piece, or the end of the text, breaks it
                  len = $urandom_range(2, 4);
                  text.push_back(utf8_lead(len));
                  repeat ($urandom_range(0, len - 2)) text.push_back(utf8_cont());
               end
            endcase
         end
         send_text(text);
         sent += text.size();
      end
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_ascii_and_controls();
      test_valid_sequences();
      test_invalid_sequences();
      test_backpressure();
      test_random_texts();

      // stop offering, let every pending byte drain, then allow for stragglers
      req_push <= 1'b0;
      while (clean_text_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
